// ===== rtl/core/rfhe_pkg.sv =====
// rfhe_pkg: shared constants, types and fixed-point helpers for the rational
// function evaluator. No dependencies.
`timescale 1ns / 1ps
package rfhe_pkg;
   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int MaxTerms  = 16;
   localparam int IdxW      = 4;
   localparam int CntW      = 5;

   localparam logic [1:0] REQ_LOAD_NUM = 2'd0;
   localparam logic [1:0] REQ_LOAD_DEN = 2'd1;
   localparam logic [1:0] REQ_EVAL_VAL = 2'd2;
   localparam logic [1:0] REQ_EVAL_DER = 2'd3;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OVF = 2'd1;
   localparam logic [1:0] ST_DZ  = 2'd2;

   localparam logic [0:0] CSR_NUM_COUNT = 1'b0;
   localparam logic [0:0] CSR_DEN_COUNT = 1'b1;

   localparam logic signed [DataWidth-1:0] ValMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] ValMin = {1'b1, {(DataWidth-1){1'b0}}};
   localparam logic signed [DataWidth-1:0] FxOne  =
      DataWidth'(64'd1 << FracBits);

   typedef logic signed [DataWidth-1:0] data_type;

   typedef struct packed {
      data_type   value;
      logic       ovf;
   } sat_type;

   // saturating add
   function automatic sat_type fx_add(input data_type a, input data_type b);
      logic signed [DataWidth:0] s;
      sat_type r;
      s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
      r.ovf = (s[DataWidth] != s[DataWidth-1]);
      r.value = r.ovf ? (s[DataWidth] ? ValMin : ValMax) : s[DataWidth-1:0];
      return r;
   endfunction

   function automatic sat_type fx_sub(input data_type a, input data_type b);
      logic signed [DataWidth:0] s;
      sat_type r;
      s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
      r.ovf = (s[DataWidth] != s[DataWidth-1]);
      r.value = r.ovf ? (s[DataWidth] ? ValMin : ValMax) : s[DataWidth-1:0];
      return r;
   endfunction

   // magnitude rounded product -> saturated value
   function automatic sat_type fx_round(input logic neg,
                                        input logic [2*DataWidth-1:0] m);
      logic [2*DataWidth-1:0] t;
      logic [DataWidth:0]     lim;
      sat_type r;
      t = (m + (2*DataWidth)'(1 << (FracBits-1))) >> FracBits;
      lim = neg ? {2'b01, {(DataWidth-1){1'b0}}} : {2'b00, {(DataWidth-1){1'b1}}};
      if (t > (2*DataWidth)'(lim)) begin
         r.ovf = 1'b1;
         r.value = neg ? ValMin : ValMax;
      end else begin
         r.ovf = 1'b0;
         r.value = neg ? -data_type'(t[DataWidth-1:0]) : data_type'(t[DataWidth-1:0]);
      end
      return r;
   endfunction

   function automatic logic [DataWidth-1:0] fx_mag(input data_type v);
      return v[DataWidth-1] ? (~v + 1'b1) : v;
   endfunction
endpackage

// ===== rtl/core/rfhe_coef_ram.sv =====
// rfhe_coef_ram: one coefficient table, synchronous write and registered read.
// Depends on rfhe_pkg.
`timescale 1ns / 1ps
module rfhe_coef_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [rfhe_pkg::IdxW-1:0]     wr_addr,
   input  rfhe_pkg::data_type            wr_data,
   input  logic [rfhe_pkg::IdxW-1:0]     rd_addr,
   output rfhe_pkg::data_type            rd_data
);
   import rfhe_pkg::*;
   data_type mem [MaxTerms];
   data_type rd_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// ===== rtl/core/rfhe_divider.sv =====
// rfhe_divider: serial restoring divider for (n << 16) / d, rounded half away
// from zero and saturated. One quotient bit per cycle. Depends on rfhe_pkg.
`timescale 1ns / 1ps
module rfhe_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  rfhe_pkg::data_type num,
   input  rfhe_pkg::data_type den,
   output logic               done,
   output rfhe_pkg::sat_type  quot
);
   import rfhe_pkg::*;
   localparam int NumW = DataWidth + FracBits + 1;
   localparam int CntBits = $clog2(NumW + 1);

   logic [NumW-1:0]      sh_ff, sh_in;
   logic [DataWidth:0]   rem_ff, rem_in;
   logic [DataWidth-1:0] dm_ff, dm_in;
   logic [NumW-1:0]      q_ff, q_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [DataWidth:0]   trial;
   logic [NumW:0]        qr;
   logic [2*DataWidth-1:0] qw;
   logic [DataWidth:0]   lim;

   always_comb begin
      sh_in = sh_ff; rem_in = rem_ff; dm_in = dm_ff; q_in = q_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      trial = {rem_ff[DataWidth-1:0], sh_ff[NumW-1]};
      if (start) begin
         sh_in = NumW'(fx_mag(num)) << (FracBits + 1);
         rem_in = '0; q_in = '0; dm_in = fx_mag(den);
         neg_in = num[DataWidth-1] ^ den[DataWidth-1];
         cnt_in = CntBits'(NumW); busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in = sh_ff << 1;
         if (trial >= {1'b0, dm_ff}) begin
            rem_in = trial - {1'b0, dm_ff};
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      sh_ff <= sh_in; rem_ff <= rem_in; dm_ff <= dm_in; q_ff <= q_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in;
   end

   // q holds one extra fraction bit; round by adding one and dropping it
   always_comb begin
      qr = ({1'b0, q_ff} + 1'b1) >> 1;
      qw = (2*DataWidth)'(qr);
      lim = neg_ff ? {2'b01, {(DataWidth-1){1'b0}}} : {2'b00, {(DataWidth-1){1'b1}}};
      if (qw > (2*DataWidth)'(lim)) begin
         quot.ovf = 1'b1;
         quot.value = neg_ff ? ValMin : ValMax;
      end else begin
         quot.ovf = 1'b0;
         quot.value = neg_ff ? -data_type'(qw[DataWidth-1:0])
                             : data_type'(qw[DataWidth-1:0]);
      end
   end
   assign done = done_ff;
endmodule

// ===== rtl/core/rational_function_horner_eval_top.sv =====
// rational_function_horner_eval_top: request decode, coefficient tables,
// Horner sequencer and quotient stage. Depends on rfhe_pkg, rfhe_coef_ram, rfhe_divider.
`timescale 1ns / 1ps
// Evaluates p(x)/q(x) or its derivative in signed Q16.16. Loads (req type 0/1)
// write one coefficient, index 0 the highest power, and give no response. An
// evaluation walks the numerator then the denominator table, one coefficient
// read from the synchronous table per step. The first coefficient of a table
// passes the states S_FIRST and S_RD, each later one S_MUL_A, S_MUL_B and S_ADD:
// two multiplies on one shared 32x32 multiplier with a register after it, then a
// saturating add. The derivative adds the quotient-rule product states S_D1 to
// S_D4, and the serial divider forms the quotient. One request is handled at a
// time; a finished response sits in an output register while the next request
// is accepted, and the sequencer only waits when a new response is ready before
// the previous one has been taken.
module rational_function_horner_eval_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [4:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // req_type
   input  logic [71:0] req_tdata,  // coef_index, coef_value, x_value, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // y_value, status, pad
);
   import rfhe_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_MUL_A = 4'd2,
      S_MUL_B = 4'd3, S_ADD = 4'd4, S_NEXTPOLY = 4'd5, S_D1 = 4'd6,
      S_D2 = 4'd7, S_D3 = 4'd8, S_D4 = 4'd9, S_DIV = 4'd10, S_WAIT = 4'd11,
      S_OUT = 4'd12, S_FIRST = 4'd13;

   logic [3:0] st_ff, st_in;
   logic [CntW-1:0] ncnt_ff, dcnt_ff;
   logic [1:0] kind_ff, kind_in;
   data_type x_ff, x_in, p_ff, p_in, pp_ff, pp_in, pv_ff, pv_in, ppv_ff, ppv_in;
   data_type m_ff, t1_ff, t1_in;
   logic poly_ff, poly_in;           // 0 numerator, 1 denominator
   logic [CntW-1:0] i_ff, i_in, n_ff, n_in;
   logic ovf_ff, ovf_in;
   logic ov_ff, ov_in;
   data_type y_ff, y_in;
   logic [1:0] sts_ff, sts_in;
   data_type rsp_y_ff, rsp_y_in;
   logic [1:0] rsp_sts_ff, rsp_sts_in;
   logic rv_ff, rv_in;
   data_type ma, mb;
   logic [2*DataWidth-1:0] mprod;
   logic mneg;
   sat_type mres, sa, sb;
   logic [IdxW-1:0] rd_addr;
   data_type num_rd, den_rd, crd;
   logic div_start, div_done;
   data_type div_n, div_d;
   sat_type div_q;
   logic [1:0] r_type;
   logic [IdxW-1:0] r_idx;
   data_type r_coef, r_x;
   logic acc;

   assign r_type = req_tuser;
   assign r_idx  = req_tdata[3:0];
   assign r_coef = req_tdata[35:4];
   assign r_x    = req_tdata[67:36];
   assign req_tready = (st_ff == S_IDLE);
   assign acc = req_tvalid && req_tready;

   rfhe_coef_ram u_num (.clock, .wr_en(acc && r_type == REQ_LOAD_NUM), .wr_addr(r_idx),
      .wr_data(r_coef), .rd_addr, .rd_data(num_rd));
   rfhe_coef_ram u_den (.clock, .wr_en(acc && r_type == REQ_LOAD_DEN), .wr_addr(r_idx),
      .wr_data(r_coef), .rd_addr, .rd_data(den_rd));
   rfhe_divider u_div (.clock, .reset, .start(div_start), .num(div_n), .den(div_d),
      .done(div_done), .quot(div_q));

   assign rd_addr = i_ff[IdxW-1:0];
   assign crd = poly_ff ? den_rd : num_rd;

   // shared multiplier, registered
   always_comb begin
      mneg = ma[DataWidth-1] ^ mb[DataWidth-1];
      mprod = (2*DataWidth)'(fx_mag(ma)) * (2*DataWidth)'(fx_mag(mb));
      mres = fx_round(mneg, mprod);
   end

   always_comb begin
      st_in = st_ff; kind_in = kind_ff; x_in = x_ff; p_in = p_ff; pp_in = pp_ff;
      pv_in = pv_ff; ppv_in = ppv_ff; t1_in = t1_ff; poly_in = poly_ff;
      i_in = i_ff; n_in = n_ff; ovf_in = ovf_ff; y_in = y_ff; sts_in = sts_ff;
      rsp_y_in = rsp_y_ff; rsp_sts_in = rsp_sts_ff;
      rv_in = rv_ff && !rsp_tready;
      ma = x_ff; mb = pp_ff; ov_in = 1'b0;
      div_start = 1'b0; div_n = p_ff; div_d = pv_ff;
      sa = fx_add(p_ff, m_ff); sb = sa;
      case (st_ff)
         S_IDLE: begin
            if (acc && (r_type == REQ_EVAL_VAL || r_type == REQ_EVAL_DER)) begin
               kind_in = r_type; x_in = r_x; ovf_in = 1'b0; poly_in = 1'b0;
               i_in = '0;
               n_in = (ncnt_ff > CntW'(MaxTerms)) ? CntW'(MaxTerms) : ncnt_ff;
               if (ncnt_ff == '0) begin
                  pv_in = FxOne; ppv_in = '0; st_in = S_NEXTPOLY;
               end else st_in = S_FIRST;
            end
         end
         S_FIRST: st_in = S_RD;           // table read in flight
         S_RD: begin
            p_in = crd; pp_in = '0; i_in = i_ff + 1'b1;
            st_in = (i_ff + 1'b1 >= n_ff) ? S_NEXTPOLY : S_MUL_A;
            if (i_ff + 1'b1 >= n_ff) begin
               if (poly_ff) begin pv_in = crd; ppv_in = '0; end
               else begin pv_in = crd; ppv_in = '0; end
            end
         end
         S_MUL_A: begin                   // m = x*pp
            ma = x_ff; mb = pp_ff; ov_in = mres.ovf; st_in = S_MUL_B;
         end
         S_MUL_B: begin                   // pp = p + m ; m = x*p
            sa = fx_add(p_ff, m_ff); pp_in = sa.value; ovf_in = ovf_ff | sa.ovf;
            ma = x_ff; mb = p_ff; ov_in = mres.ovf; st_in = S_ADD;
         end
         S_ADD: begin                     // p = c[i] + m, c[i] read since i set
            sb = fx_add(crd, m_ff); p_in = sb.value; ovf_in = ovf_ff | sb.ovf;
            i_in = i_ff + 1'b1;
            if (i_ff + 1'b1 >= n_ff) begin
               pv_in = sb.value; ppv_in = pp_ff; st_in = S_NEXTPOLY;
            end else st_in = S_MUL_A;
         end
         S_NEXTPOLY: begin
            if (!poly_ff) begin
               // park numerator result in p/pp, start denominator
               p_in = pv_ff; pp_in = ppv_ff;
               t1_in = pv_ff; y_in = ppv_ff;
               poly_in = 1'b1; i_in = '0;
               n_in = (dcnt_ff > CntW'(MaxTerms)) ? CntW'(MaxTerms) : dcnt_ff;
               if (dcnt_ff == '0) begin
                  y_in = (kind_ff == REQ_EVAL_VAL) ? pv_ff : ppv_ff;
                  sts_in = ovf_ff ? ST_OVF : ST_OK; st_in = S_OUT;
               end else st_in = S_FIRST;
            end else begin
               // t1 = p, y = pp (numerator); pv = q, ppv = q'
               if (kind_ff == REQ_EVAL_VAL) begin
                  p_in = t1_ff; st_in = S_DIV;
               end else st_in = S_D1;
            end
         end
         S_D1: begin                      // m = pp*q
            ma = y_ff; mb = pv_ff; ov_in = mres.ovf; st_in = S_D2;
         end
         S_D2: begin                      // pp = m ; m = p*q'
            pp_in = m_ff; ovf_in = ovf_ff | ov_ff;
            ma = t1_ff; mb = ppv_ff; ov_in = mres.ovf; st_in = S_D3;
         end
         S_D3: begin                      // p = pp - m ; m = q*q
            sa = fx_sub(pp_ff, m_ff); p_in = sa.value;
            ovf_in = ovf_ff | ov_ff | sa.ovf;
            ma = pv_ff; mb = pv_ff; ov_in = mres.ovf; st_in = S_D4;
         end
         S_D4: begin
            pv_in = m_ff; ovf_in = ovf_ff | ov_ff; st_in = S_DIV;
         end
         S_DIV: begin
            if (pv_ff == '0) begin
               y_in = p_ff[DataWidth-1] ? ValMin : ValMax;
               sts_in = ST_DZ; st_in = S_OUT;
            end else begin
               div_start = 1'b1; st_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (div_done) begin
               y_in = div_q.value;
               sts_in = (ovf_ff | div_q.ovf) ? ST_OVF : ST_OK; st_in = S_OUT;
            end
         end
         S_OUT: begin
            // move the result into the output register once it is free
            if (!rv_ff || rsp_tready) begin
               rsp_y_in = y_ff; rsp_sts_in = sts_ff;
               rv_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
      // multiplier overflow from the state that filled m
      if (st_ff == S_MUL_B || st_ff == S_ADD) ovf_in = ovf_in | ov_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rv_ff <= 1'b0; ncnt_ff <= '0; dcnt_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rv_ff <= rv_in; ov_ff <= ov_in;
         if (csr_we && csr_index == CSR_NUM_COUNT) ncnt_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_DEN_COUNT) dcnt_ff <= csr_wdata;
      end
      kind_ff <= kind_in; x_ff <= x_in; p_ff <= p_in; pp_ff <= pp_in;
      pv_ff <= pv_in; ppv_ff <= ppv_in; t1_ff <= t1_in; poly_ff <= poly_in;
      i_ff <= i_in; n_ff <= n_in; ovf_ff <= ovf_in; y_ff <= y_in; sts_ff <= sts_in;
      rsp_y_ff <= rsp_y_in; rsp_sts_ff <= rsp_sts_in;
      m_ff <= mres.value;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {6'd0, rsp_sts_ff, rsp_y_ff};
endmodule

// ===== sim/tb_rational_function_horner_eval_top.sv =====
// tb_rational_function_horner_eval_top: self-checking bench for the rational function
// evaluator, directed table then random phases checked against a Q16.16 predictor.
// Depends on rfhe_pkg and rational_function_horner_eval_top.
`timescale 1ns / 1ps
module tb_rational_function_horner_eval_top;
   import rfhe_pkg::*;

   localparam int   DRAIN_CYCLES  = 400;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam longint FX_MAX = 64'sd2147483647;
   localparam longint FX_MIN = -64'sd2147483648;

   typedef enum logic [1:0] {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_type;
   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0] req;
      logic [3:0] idx;
      logic [31:0] coef;
      logic [31:0] x;
      logic       has_exp;
      logic [31:0] exp_y;
      logic [1:0] exp_st;
   } dir_row_type;

   typedef struct {
      logic [31:0] y;
      logic [1:0]  st;
   } eval_result_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [4:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   rational_function_horner_eval_top DUT (.*);

   // predictor state
   longint      num_tab [MaxTerms];
   longint      den_tab [MaxTerms];
   int          num_cnt, den_cnt;
   eval_result_type pending_results[$];
   int          errors = 0;
   longint      cycles = 0;
   pace_type    pace;
   dir_row_type dir_rows[$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("rational_function_horner_eval_top test failed");
         $finish;
      end
   end

   function automatic int send_idle_pct(input pace_type pc);
      return (pc == PACE_SEND_IDLE) ? 59 : ((pc == PACE_BOTH) ? 21 : 0);
   endfunction

   function automatic int recv_stall_pct(input pace_type pc);
      return (pc == PACE_RECV_STALL) ? 59 : ((pc == PACE_BOTH) ? 21 : 0);
   endfunction

   function automatic longint fx_sat(input bit neg, input longint unsigned m, inout bit ovf);
      longint unsigned lim;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (m > lim) begin
         ovf = 1'b1;
         return neg ? FX_MIN : FX_MAX;
      end
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned fx_abs(input longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   function automatic longint fx_times(input longint a, input longint b, inout bit ovf);
      longint unsigned m;
      m = (fx_abs(a) * fx_abs(b) + 64'd32768) >> 16;
      return fx_sat((a < 0) != (b < 0), m, ovf);
   endfunction

   function automatic longint fx_plus(input longint a, input longint b, inout bit ovf);
      longint s;
      s = a + b;
      if (s > FX_MAX) begin ovf = 1'b1; return FX_MAX; end
      if (s < FX_MIN) begin ovf = 1'b1; return FX_MIN; end
      return s;
   endfunction

   function automatic longint fx_quot(input longint n, input longint d, inout bit ovf,
                                      inout bit dz);
      longint unsigned q;
      if (d == 0) begin
         dz = 1'b1;
         return n < 0 ? FX_MIN : FX_MAX;
      end
      q = ((fx_abs(n) << 17) / fx_abs(d) + 1) >> 1;
      return fx_sat((n < 0) != (d < 0), q, ovf);
   endfunction

   // value and slope of one polynomial in a single horner pass
   function automatic void poly_eval(input bit use_den, input int cnt, input longint x,
                                     output longint v, output longint dv, inout bit ovf);
      longint c;
      v = use_den ? den_tab[0] : num_tab[0];
      dv = 0;
      for (int i = 1; i < cnt; i++) begin
         c = use_den ? den_tab[i] : num_tab[i];
         dv = fx_plus(v, fx_times(x, dv, ovf), ovf);
         v = fx_plus(c, fx_times(x, v, ovf), ovf);
      end
   endfunction

   function automatic eval_result_type rational_eval(input logic [1:0] req,
                                                     input logic [31:0] xr);
      longint x, p, pp, q, qp, y, t1, t2, nn, qq;
      int na, nb;
      bit ovf, dz;
      eval_result_type r;
      ovf = 0;
      dz = 0;
      x = longint'($signed(xr));
      na = num_cnt > MaxTerms ? MaxTerms : num_cnt;
      nb = den_cnt > MaxTerms ? MaxTerms : den_cnt;
      if (na == 0) begin
         p = 64'sd65536;
         pp = 0;
      end else
         poly_eval(1'b0, na, x, p, pp, ovf);
      if (nb == 0)
         y = (req == REQ_EVAL_VAL) ? p : pp;
      else begin
         poly_eval(1'b1, nb, x, q, qp, ovf);
         if (req == REQ_EVAL_VAL)
            y = fx_quot(p, q, ovf, dz);
         else begin
            t1 = fx_times(pp, q, ovf);
            t2 = fx_times(p, qp, ovf);
            nn = fx_plus(t1, -t2, ovf);
            qq = fx_times(q, q, ovf);
            y = fx_quot(nn, qq, ovf, dz);
         end
      end
      r.y = y[31:0];
      r.st = dz ? ST_DZ : (ovf ? ST_OVF : ST_OK);
      return r;
   endfunction

   function automatic logic [31:0] rand_fx();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 32'h0004_0000);
         2: v = $urandom_range(0, 32'h0000_8000);
         default: begin
            case ($urandom_range(0, 3))
               0: v = ValMax;
               1: v = ValMin;
               2: v = 32'h0001_0000;
               default: v = 32'h0;
            endcase
         end
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_count(input logic which, input int value);
      wait_drained();
      csr_we = 1'b1;
      csr_index = which;
      csr_wdata = value[4:0];
      @(negedge clock);
      csr_we = 1'b0;
      if (which == CSR_NUM_COUNT) num_cnt = value;
      else den_cnt = value;
   endtask

   // present one request from a falling edge and hold it until accepted
   task automatic send_request(input logic [1:0] req, input logic [3:0] idx,
                               input logic [31:0] coef, input logic [31:0] x,
                               input bit has_exp, input eval_result_type typed);
      int idle_pct;
      idle_pct = send_idle_pct(pace);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = req;
      req_tdata = {4'b0000, x, coef, idx};
      do @(posedge clock); while (!req_tready);
      if (req == REQ_LOAD_NUM) num_tab[idx] = longint'($signed(coef));
      else if (req == REQ_LOAD_DEN) den_tab[idx] = longint'($signed(coef));
      else pending_results.push_back(has_exp ? typed : rational_eval(req, x));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct(pace));

   always @(posedge clock) begin
      eval_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response y_value=%h status=%0d", rsp_tdata[31:0],
                   rsp_tdata[33:32]);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_tdata[31:0] !== e.y) begin
               $error("y_value expected %h actual %h", e.y, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[33:32] !== e.st) begin
               $error("status expected %0d actual %0d", e.st, rsp_tdata[33:32]);
               errors++;
            end
         end
      end
   end

   initial begin
      eval_result_type none;
      int num_set[12] = '{0, 16, 1, 31, 4, 0, 7, 16, 2, 3, 5, 1};
      int den_set[12] = '{0, 16, 1, 31, 3, 5, 0, 1, 16, 2, 5, 0};
      logic [1:0] req;

      none = '{32'h0, ST_OK};
      pace = PACE_FULL;
      num_cnt = 0;
      den_cnt = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_NUM_COUNT;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows: after reset both counts are zero so p = 1
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_VAL, 0, 0, 32'h0, 1, 32'h0001_0000, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_DER, 0, 0, ValMin, 1, 32'h0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_LOAD_NUM, 0, ValMin, 0, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_LOAD_DEN, 0, 32'h0, ValMax, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_LOAD_NUM, 15, ValMax, 0, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_LOAD_DEN, 15, ValMin, 0, 0, 0, ST_OK});
      // zero divisor
      dir_rows.push_back('{ROW_CSR, CSR_DEN_COUNT, 1, 0, 0, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_VAL, 0, 0, 32'h5, 1, ValMax, ST_DZ});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_DER, 0, 0, ValMax, 1, ValMax, ST_DZ});
      dir_rows.push_back('{ROW_CSR, CSR_NUM_COUNT, 1, 0, 0, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_VAL, 0, 0, 32'h7, 1, ValMin, ST_DZ});
      // no division: constant numerator
      dir_rows.push_back('{ROW_CSR, CSR_DEN_COUNT, 0, 0, 0, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_VAL, 0, 0, ValMax, 1, ValMin, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_DER, 0, 0, ValMin, 1, 32'h0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_LOAD_NUM, 1, ValMax, 0, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_LOAD_DEN, 1, 32'h0001_0000, 0, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_LOAD_DEN, 0, 32'h0002_0000, 0, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_CSR, CSR_NUM_COUNT, 2, 0, 0, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_VAL, 0, 0, ValMax, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_DER, 0, 0, ValMin, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_CSR, CSR_DEN_COUNT, 2, 0, 0, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_VAL, 0, 0, 32'hFFFF_0000, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_DER, 0, 0, 32'h0000_8000, 0, 0, ST_OK});
      dir_rows.push_back('{ROW_REQ, REQ_EVAL_VAL, 0, 0, 32'h0, 0, 0, ST_OK});

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR)
            write_count(dir_rows[i].req[0], int'(dir_rows[i].idx));
         else
            send_request(dir_rows[i].req, dir_rows[i].idx, dir_rows[i].coef, dir_rows[i].x,
                         dir_rows[i].has_exp, '{dir_rows[i].exp_y, dir_rows[i].exp_st});
      end

      // fill both tables so any count reads written entries only
      for (int i = 0; i < MaxTerms; i++) begin
         send_request(REQ_LOAD_NUM, i[3:0], rand_fx(), $urandom, 0, none);
         send_request(REQ_LOAD_DEN, i[3:0], rand_fx(), $urandom, 0, none);
      end

      for (int ph = 0; ph < 12; ph++) begin
         req_tvalid = 1'b0;
         write_count(CSR_NUM_COUNT, num_set[ph]);
         write_count(CSR_DEN_COUNT, den_set[ph]);
         pace = pace_type'(ph % 4);
         for (int n = 0; n < 150; n++) begin
            if (ph == 2 && n == 75) begin
               req_tvalid = 1'b0;
               while (pending_results.size() != 0) @(negedge clock);
            end
            req = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 1))
                                              : 2'($urandom_range(2, 3));
            send_request(req, 4'($urandom_range(0, 15)), rand_fx(), rand_fx(), 0, none);
         end
      end
      req_tvalid = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("rational_function_horner_eval_top test passed");
      else
         $display("rational_function_horner_eval_top test failed");
      $finish;
   end
endmodule
